FILE: rtl/core/ktx_texture_header_parser_assert.svh
// Assertion macros shared by the parser modules.
`ifndef KTX_TEXTURE_HEADER_PARSER_ASSERT_SVH
`define KTX_TEXTURE_HEADER_PARSER_ASSERT_SVH

// Property must hold at every edge outside reset.
`define KTX_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define KTX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/ktx_pkg.sv
package ktx_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_LEVEL   = 2'd1,
    KIND_ACCEPT  = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NOT_KTX   = 3'd1,
    ERR_FORMAT    = 3'd2,
    ERR_ARRAY     = 3'd3,
    ERR_DEPTH     = 3'd4,
    ERR_CUBEMAP   = 3'd5,
    ERR_TRUNCATED = 3'd6
  } err_t;

  localparam logic [5:0] FmtNone = 6'd57;
  localparam logic [31:0] EndianNative = 32'h04030201;
  localparam logic [31:0] EndianSwapped = 32'h01020304;

  function automatic logic [7:0] ident_byte(input logic [3:0] idx);
    logic [7:0] r;
    begin
      case (idx)
        4'd0: r = 8'hAB;
        4'd1: r = 8'h4B;
        4'd2: r = 8'h54;
        4'd3: r = 8'h58;
        4'd4: r = 8'h20;
        4'd5: r = 8'h31;
        4'd6: r = 8'h31;
        4'd7: r = 8'hBB;
        4'd8: r = 8'h0D;
        4'd9: r = 8'h0A;
        4'd10: r = 8'h1A;
        4'd11: r = 8'h0A;
        default: r = 8'h00;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Maps a format enum value to its index, FmtNone when unsupported.
  function automatic logic [5:0] fmt_lookup(input logic [31:0] w);
    logic [5:0] r;
    begin
      r = FmtNone;
      if (w[31:16] == 16'h0) begin
        if (w[15:0] == 16'h8D64) r = 6'd0;
        else if (w[15:4] == 12'h927 && w[3:0] <= 4'h9) r = 6'(4'd1 + w[3:0]);
        else if (w[15:2] == 14'(16'h8C00 >> 2)) r = 6'(4'd11 + w[1:0]);
        else if (w[15:0] == 16'h83F0) r = 6'd15;
        else if (w[15:0] == 16'h83F2) r = 6'd16;
        else if (w[15:0] == 16'h83F3) r = 6'd17;
        else if (w[15:0] == 16'h8C4C) r = 6'd18;
        else if (w[15:0] == 16'h8C4E) r = 6'd19;
        else if (w[15:0] == 16'h8C4F) r = 6'd20;
        else if (w[15:0] >= 16'h8DBB && w[15:0] <= 16'h8DBE) r = 6'(w[15:0] - 16'h8DBB + 16'd21);
        else if (w[15:2] == 14'(16'h8E8C >> 2)) r = 6'(5'd25 + w[1:0]);
        else if (w[15:0] >= 16'h93B0 && w[15:0] <= 16'h93BD) r = 6'(w[15:0] - 16'h93B0 + 16'd29);
        else if (w[15:0] >= 16'h93D0 && w[15:0] <= 16'h93DD) r = 6'(w[15:0] - 16'h93D0 + 16'd43);
      end
      return r;
    end
  endfunction

  function automatic logic [31:0] dim_at(input logic [31:0] base, input logic [31:0] lvl);
    logic [31:0] v;
    begin
      v = (lvl < 32'd32) ? (base >> lvl[4:0]) : 32'd0;
      return (v == 32'd0) ? 32'd1 : v;
    end
  endfunction

endpackage

FILE: rtl/core/ktx_out_reg.sv
// Result register with skid stage: holds up to two result requests.
module ktx_out_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] out_data
);
  logic         main_v_r, skid_v_r;
  logic [W-1:0] main_r, skid_r;

  assign out_valid = main_v_r;
  assign out_data  = main_r;
  assign in_stall  = skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!main_v_r || !out_stall) begin
        if (skid_v_r) begin
          main_r   <= skid_r;
          main_v_r <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          main_r   <= in_data;
          main_v_r <= in_valid;
        end
      end else if (in_valid && !skid_v_r) begin
        skid_r   <= in_data;
        skid_v_r <= 1'b1;
      end
    end
  end

  `include "ktx_texture_header_parser_assert.svh"
  `KTX_ASSERT(a_skid_implies_main, !skid_v_r || main_v_r)
  `KTX_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `KTX_ASSERT_NEXT(a_no_loss, in_valid && !in_stall && out_valid && out_stall, skid_v_r)
endmodule

FILE: rtl/core/ktx_texture_header_parser.sv
// KTX1 texture file parser. One file byte is taken per cycle on the in_ channel
// while in_stall is low (last_in marks the end of a file); each byte yields up to
// two results, and after a byte that yields two, in_stall stays high until the
// second result has entered the output queue. Sustained rate is one byte per cycle
// when every byte yields at most one result and out_stall stays low.
// Results pass through a two-entry output queue that decouples the two sides.
module ktx_texture_header_parser #(
  parameter int OFFSET_WIDTH = 40
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_byte,
  input  logic                    last_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_kind,
  output logic [2:0]              out_error_code,
  output logic [7:0]              out_data_byte,
  output logic [OFFSET_WIDTH-1:0] out_dest_offset,
  output logic [31:0]             out_level,
  output logic [31:0]             out_width,
  output logic [31:0]             out_height,
  output logic [31:0]             out_mip_bytes,
  output logic [5:0]              out_format_code,
  output logic                    out_last
);
  import ktx_pkg::*;

  localparam int RW = 2 + 3 + 8 + OFFSET_WIDTH + 32 * 4 + 6 + 1;

  typedef enum logic [2:0] {
    PH_HEADER, PH_SKIP, PH_SIZE, PH_DATA, PH_PAD, PH_DONE, PH_ERROR
  } phase_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [2:0]              code;
    logic [7:0]              dbyte;
    logic [OFFSET_WIDTH-1:0] off;
    logic [31:0]             lvl;
    logic [31:0]             w;
    logic [31:0]             h;
    logic [31:0]             mb;
    logic [5:0]              fc;
    logic                    last;
  } res_t;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  hidx_r, hidx_nxt;
  logic [31:0] hw_r [13];
  logic [31:0] hw_nxt [13];
  logic        ident_ok_r, ident_ok_nxt, rev_r, rev_nxt;
  logic [31:0] skip_r, skip_nxt, lcnt_r, lcnt_nxt, ltot_r, ltot_nxt;
  logic [1:0]  ws_r, ws_nxt, pad_r, pad_nxt;
  logic [31:0] bl_r, bl_nxt;
  logic [OFFSET_WIDTH-1:0] off_r, off_nxt;
  logic [5:0]  fmt_r, fmt_nxt;

  // pending second result of the current byte
  logic        pend_v_r;
  res_t        pend_r;

  res_t r0, r1;
  logic n0, n1;
  logic q_stall, q_valid;
  res_t q_data, q_out;
  logic take;

  assign in_stall = pend_v_r || q_stall;
  assign take = in_valid && !in_stall;

  function automatic res_t mk(input logic [1:0] k, input logic [2:0] c, input logic [7:0] d,
                              input logic [OFFSET_WIDTH-1:0] o, input logic [31:0] l,
                              input logic [31:0] w, input logic [31:0] h,
                              input logic [31:0] m, input logic [5:0] f);
    res_t r;
    begin
      r.kind = k; r.code = c; r.dbyte = d; r.off = o; r.lvl = l;
      r.w = w; r.h = h; r.mb = m; r.fc = f; r.last = 1'b0;
      return r;
    end
  endfunction

  always_comb begin
    logic [5:0]  k;
    logic [31:0] e, bw;
    logic [5:0]  f;
    logic        have_r1, fin_lvl;
    phase_nxt = phase_r; hidx_nxt = hidx_r;
    for (int i = 0; i < 13; i++) hw_nxt[i] = hw_r[i];
    ident_ok_nxt = ident_ok_r; rev_nxt = rev_r; skip_nxt = skip_r;
    lcnt_nxt = lcnt_r; ltot_nxt = ltot_r; ws_nxt = ws_r; pad_nxt = pad_r;
    bl_nxt = bl_r; off_nxt = off_r; fmt_nxt = fmt_r;
    r0 = '0; r1 = '0; n0 = 1'b0; have_r1 = 1'b0; fin_lvl = 1'b0;
    k = 6'(hidx_r - 6'd12); e = '0; bw = '0; f = '0;
    unique case (phase_r)
      PH_HEADER: begin
        if (hidx_r < 6'd12) begin
          if (in_byte != ident_byte(hidx_r[3:0])) ident_ok_nxt = 1'b0;
        end else begin
          hw_nxt[k[5:2]] = hw_r[k[5:2]] | (32'(in_byte) << {k[1:0], 3'b000});
        end
        hidx_nxt = 6'(hidx_r + 6'd1);
        if (hidx_r == 6'd63) begin
          e = hw_r[0];
          if (!ident_ok_nxt || (e != EndianNative && e != EndianSwapped)) begin
            n0 = 1'b1; r0 = mk(KIND_ERROR, ERR_NOT_KTX, '0, '0, '0, '0, '0, '0, '0);
            phase_nxt = PH_ERROR;
          end else begin
            rev_nxt = (e == EndianSwapped);
            if (rev_nxt) for (int i = 1; i < 13; i++) hw_nxt[i] = swap32(hw_nxt[i]);
            f = fmt_lookup(hw_nxt[4]);
            phase_nxt = PH_ERROR; n0 = 1'b1;
            if (f == FmtNone) r0 = mk(KIND_ERROR, ERR_FORMAT, '0, '0, '0, '0, '0, '0, '0);
            else if (hw_nxt[9] != 0) r0 = mk(KIND_ERROR, ERR_ARRAY, '0, '0, '0, '0, '0, '0, '0);
            else if (hw_nxt[8] > 1) r0 = mk(KIND_ERROR, ERR_DEPTH, '0, '0, '0, '0, '0, '0, '0);
            else if (hw_nxt[10] > 1)
              r0 = mk(KIND_ERROR, ERR_CUBEMAP, '0, '0, '0, '0, '0, '0, '0);
            else begin
              n0 = 1'b0;
              fmt_nxt = f;
              ltot_nxt = (hw_nxt[11] != 0) ? hw_nxt[11] : 32'd1;
              skip_nxt = hw_nxt[12];
              lcnt_nxt = '0; ws_nxt = '0; bl_nxt = '0; off_nxt = '0;
              phase_nxt = (hw_nxt[12] != 0) ? PH_SKIP : PH_SIZE;
            end
          end
        end else if (last_in) begin
          n0 = 1'b1; r0 = mk(KIND_ERROR, ERR_NOT_KTX, '0, '0, '0, '0, '0, '0, '0);
          phase_nxt = PH_ERROR;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_r - 32'd1;
        if (skip_nxt == 0) phase_nxt = PH_SIZE;
      end
      PH_SIZE: begin
        bw = bl_r | (32'(in_byte) << {ws_r, 3'b000});
        ws_nxt = 2'(ws_r + 2'd1);
        bl_nxt = bw;
        if (ws_r == 2'd3) begin
          if (rev_r) bw = swap32(bw);
          bl_nxt = bw;
          pad_nxt = 2'(-bw[1:0]);
          n0 = 1'b1;
          r0 = mk(KIND_LEVEL, ERR_NONE, '0, off_r, lcnt_r, dim_at(hw_r[6], lcnt_r),
                  dim_at(hw_r[7], lcnt_r), bw, fmt_r);
          if (bw == 0) fin_lvl = 1'b1;
          else phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        n0 = 1'b1;
        r0 = mk(KIND_PAYLOAD, ERR_NONE, in_byte, off_r, lcnt_r, '0, '0, '0, fmt_r);
        off_nxt = OFFSET_WIDTH'(off_r + 1'b1);
        bl_nxt = bl_r - 32'd1;
        if (bl_nxt == 0) fin_lvl = 1'b1;
      end
      PH_PAD: begin
        pad_nxt = 2'(pad_r - 2'd1);
        if (pad_nxt == 0) phase_nxt = PH_SIZE;
      end
      default: ;
    endcase
    if (fin_lvl) begin
      if (lcnt_r == ltot_r - 32'd1) begin
        have_r1 = 1'b1;
        r1 = mk(KIND_ACCEPT, ERR_NONE, '0, '0, '0, '0, '0, '0, fmt_r);
        phase_nxt = PH_DONE;
      end else begin
        off_nxt = OFFSET_WIDTH'(off_nxt + OFFSET_WIDTH'(pad_nxt));
        lcnt_nxt = lcnt_r + 32'd1;
        ws_nxt = '0; bl_nxt = '0;
        phase_nxt = (pad_nxt != 0) ? PH_PAD : PH_SIZE;
      end
    end
    if (last_in) begin
      if (phase_nxt != PH_DONE && phase_nxt != PH_ERROR) begin
        have_r1 = 1'b1;
        r1 = mk(KIND_ERROR, ERR_TRUNCATED, '0, '0, '0, '0, '0, '0, '0);
      end
      phase_nxt = PH_HEADER; hidx_nxt = '0;
      for (int i = 0; i < 13; i++) hw_nxt[i] = '0;
      ident_ok_nxt = 1'b1; rev_nxt = 1'b0; skip_nxt = '0; lcnt_nxt = '0;
      ltot_nxt = '0; ws_nxt = '0; bl_nxt = '0; pad_nxt = '0; off_nxt = '0; fmt_nxt = '0;
    end
    // compact: r0 first, r1 second; only one result present goes to r0
    if (!n0 && have_r1) begin
      r0 = r1; n0 = 1'b1; have_r1 = 1'b0;
    end
    n1 = have_r1;
    if (n1) r1.last = 1'b1;
    else r0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; hidx_r <= '0; ident_ok_r <= 1'b1; rev_r <= 1'b0;
      skip_r <= '0; lcnt_r <= '0; ltot_r <= '0; ws_r <= '0; bl_r <= '0;
      pad_r <= '0; off_r <= '0; fmt_r <= '0; pend_v_r <= 1'b0;
      for (int i = 0; i < 13; i++) hw_r[i] <= '0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt; hidx_r <= hidx_nxt; ident_ok_r <= ident_ok_nxt;
        rev_r <= rev_nxt; skip_r <= skip_nxt; lcnt_r <= lcnt_nxt; ltot_r <= ltot_nxt;
        ws_r <= ws_nxt; bl_r <= bl_nxt; pad_r <= pad_nxt; off_r <= off_nxt;
        fmt_r <= fmt_nxt;
        for (int i = 0; i < 13; i++) hw_r[i] <= hw_nxt[i];
        if (n0 && n1) begin
          pend_v_r <= 1'b1;
          pend_r   <= r1;
        end
      end else if (pend_v_r && !q_stall) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // queue input: pending result first, then the new byte's first result
  assign q_valid = pend_v_r || (take && n0);
  assign q_data  = pend_v_r ? pend_r : r0;

  ktx_out_reg #(.W(RW)) u_out (
    .clk(clk), .rst_n(rst_n),
    .in_valid(q_valid), .in_stall(q_stall), .in_data(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(q_out)
  );

  assign out_kind        = q_out.kind;
  assign out_error_code  = q_out.code;
  assign out_data_byte   = q_out.dbyte;
  assign out_dest_offset = q_out.off;
  assign out_level       = q_out.lvl;
  assign out_width       = q_out.w;
  assign out_height      = q_out.h;
  assign out_mip_bytes   = q_out.mb;
  assign out_format_code = q_out.fc;
  assign out_last        = q_out.last;

  `include "ktx_texture_header_parser_assert.svh"
  `KTX_ASSERT_NEXT(a_fin_restart, take && last_in, phase_r == PH_HEADER && hidx_r == 6'd0)
  `KTX_ASSERT_NEXT(a_pend_two, take && n0 && n1, pend_v_r)
  `KTX_ASSERT(a_pend_blocks, !pend_v_r || in_stall)
endmodule

FILE: bench/ktx_texture_header_parser_tb.sv
`timescale 1ns / 100ps

module ktx_texture_header_parser_tb;
  import ktx_pkg::*;

  localparam int OW = 40;
  localparam longint unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } req_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [2:0]    code;
    logic [7:0]    dbyte;
    logic [OW-1:0] off;
    logic [31:0]   lvl;
    logic [31:0]   w;
    logic [31:0]   h;
    logic [31:0]   mb;
    logic [5:0]    fc;
    logic          last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = '0;
  logic last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [2:0] out_error_code;
  logic [7:0] out_data_byte;
  logic [OW-1:0] out_dest_offset;
  logic [31:0] out_level, out_width, out_height, out_mip_bytes;
  logic [5:0] out_format_code;
  logic out_last;

  ktx_texture_header_parser #(.OFFSET_WIDTH(OW)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t byte_q[$];
  res_t result_q[$];
  int errors = 0;
  int send_idle_pct = 30;
  int recv_idle_pct = 82;
  int hold_cycles = 0;
  bit all_sent = 0;
  bit in_taken = 0;
  longint unsigned cycle_cnt = 0;

  // parser shadow state
  typedef enum int {S_HDR, S_SKIP, S_SIZE, S_DATA, S_PAD, S_DONE, S_ERR} pstate_t;
  pstate_t ps;
  int unsigned hidx;
  logic [31:0] hw[13];
  bit id_ok, rev;
  logic [31:0] skip_cnt, lvl_cnt, lvl_tot, wsh, left;
  logic [1:0] pad_cnt;
  logic [OW-1:0] dst;
  logic [5:0] fidx;

  function automatic logic [31:0] bswap(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [31:0] shrink(logic [31:0] base, logic [31:0] l);
    logic [31:0] v;
    v = (l < 32) ? base >> l : 32'd0;
    return (v == 0) ? 32'd1 : v;
  endfunction

  function automatic int fmt_index_of(logic [31:0] w);
    logic [15:0] t[57];
    int k;
    t = '{16'h8D64, 16'h9270, 16'h9271, 16'h9272, 16'h9273, 16'h9274, 16'h9275,
          16'h9276, 16'h9277, 16'h9278, 16'h9279, 16'h8C00, 16'h8C01, 16'h8C02,
          16'h8C03, 16'h83F0, 16'h83F2, 16'h83F3, 16'h8C4C, 16'h8C4E, 16'h8C4F,
          16'h8DBB, 16'h8DBC, 16'h8DBD, 16'h8DBE, 16'h8E8C, 16'h8E8D, 16'h8E8E,
          16'h8E8F, 16'h93B0, 16'h93B1, 16'h93B2, 16'h93B3, 16'h93B4, 16'h93B5,
          16'h93B6, 16'h93B7, 16'h93B8, 16'h93B9, 16'h93BA, 16'h93BB, 16'h93BC,
          16'h93BD, 16'h93D0, 16'h93D1, 16'h93D2, 16'h93D3, 16'h93D4, 16'h93D5,
          16'h93D6, 16'h93D7, 16'h93D8, 16'h93D9, 16'h93DA, 16'h93DB, 16'h93DC,
          16'h93DD};
    for (k = 0; k < 57; k++) if (w == {16'h0, t[k]}) return k;
    return -1;
  endfunction

  function automatic logic [15:0] fmt_value(int k);
    logic [15:0] t[57];
    t = '{16'h8D64, 16'h9270, 16'h9271, 16'h9272, 16'h9273, 16'h9274, 16'h9275,
          16'h9276, 16'h9277, 16'h9278, 16'h9279, 16'h8C00, 16'h8C01, 16'h8C02,
          16'h8C03, 16'h83F0, 16'h83F2, 16'h83F3, 16'h8C4C, 16'h8C4E, 16'h8C4F,
          16'h8DBB, 16'h8DBC, 16'h8DBD, 16'h8DBE, 16'h8E8C, 16'h8E8D, 16'h8E8E,
          16'h8E8F, 16'h93B0, 16'h93B1, 16'h93B2, 16'h93B3, 16'h93B4, 16'h93B5,
          16'h93B6, 16'h93B7, 16'h93B8, 16'h93B9, 16'h93BA, 16'h93BB, 16'h93BC,
          16'h93BD, 16'h93D0, 16'h93D1, 16'h93D2, 16'h93D3, 16'h93D4, 16'h93D5,
          16'h93D6, 16'h93D7, 16'h93D8, 16'h93D9, 16'h93DA, 16'h93DB, 16'h93DC,
          16'h93DD};
    return t[k];
  endfunction

  task automatic parser_clear();
    ps = S_HDR; hidx = 0; id_ok = 1; rev = 0;
    foreach (hw[i]) hw[i] = '0;
    skip_cnt = 0; lvl_cnt = 0; lvl_tot = 0; wsh = 0; left = 0;
    pad_cnt = 0; dst = '0; fidx = '0;
  endtask

  task automatic push_result(ref res_t r[$], input logic [1:0] k, input logic [2:0] c,
                             input logic [7:0] d, input logic [OW-1:0] o,
                             input logic [31:0] l, w, h, mb, input logic [5:0] f);
    res_t x;
    x = '{k, c, d, o, l, w, h, mb, f, 1'b0};
    r.insert(r.size(), x);
  endtask

  task automatic report_error(ref res_t r[$], input err_t e);
    push_result(r, KIND_ERROR, e, 0, 0, 0, 0, 0, 0, 0);
    ps = S_ERR;
  endtask

  task automatic level_end(ref res_t r[$]);
    if (lvl_cnt == lvl_tot - 1) begin
      push_result(r, KIND_ACCEPT, ERR_NONE, 0, 0, 0, 0, 0, 0, fidx);
      ps = S_DONE;
    end else begin
      dst = dst + pad_cnt;
      lvl_cnt++;
      wsh = 0; left = 0;
      ps = pad_cnt ? S_PAD : S_SIZE;
    end
  endtask

  task automatic header_check(ref res_t r[$]);
    int f;
    if (!id_ok || (hw[0] != EndianNative && hw[0] != EndianSwapped)) begin
      report_error(r, ERR_NOT_KTX); return;
    end
    rev = (hw[0] == EndianSwapped);
    if (rev) for (int i = 1; i < 13; i++) hw[i] = bswap(hw[i]);
    f = fmt_index_of(hw[4]);
    if (f < 0) begin report_error(r, ERR_FORMAT); return; end
    fidx = f[5:0];
    if (hw[9] > 0) begin report_error(r, ERR_ARRAY); return; end
    if (hw[8] > 1) begin report_error(r, ERR_DEPTH); return; end
    if (hw[10] > 1) begin report_error(r, ERR_CUBEMAP); return; end
    lvl_tot = hw[11] ? hw[11] : 32'd1;
    skip_cnt = hw[12];
    lvl_cnt = 0; wsh = 0; left = 0; dst = '0;
    ps = skip_cnt ? S_SKIP : S_SIZE;
  endtask

  task automatic predict_byte(input req_t q);
    res_t r[$];
    logic [7:0] idb[12];
    int k;
    idb = '{8'hAB, 8'h4B, 8'h54, 8'h58, 8'h20, 8'h31, 8'h31, 8'hBB,
            8'h0D, 8'h0A, 8'h1A, 8'h0A};
    case (ps)
      S_HDR: begin
        if (hidx < 12) begin
          if (q.b != idb[hidx]) id_ok = 0;
        end else begin
          k = hidx - 12;
          hw[k / 4] |= 32'(q.b) << (8 * (k % 4));
        end
        hidx++;
        if (hidx == 64) header_check(r);
        else if (q.fin) report_error(r, ERR_NOT_KTX);
      end
      S_SKIP: begin
        skip_cnt--;
        if (skip_cnt == 0) ps = S_SIZE;
      end
      S_SIZE: begin
        left |= 32'(q.b) << (8 * wsh);
        wsh++;
        if (wsh == 4) begin
          if (rev) left = bswap(left);
          pad_cnt = 2'(-left);
          wsh = 0;
          push_result(r, KIND_LEVEL, ERR_NONE, 0, dst, lvl_cnt, shrink(hw[6], lvl_cnt),
                      shrink(hw[7], lvl_cnt), left, fidx);
          if (left == 0) level_end(r);
          else ps = S_DATA;
        end
      end
      S_DATA: begin
        push_result(r, KIND_PAYLOAD, ERR_NONE, q.b, dst, lvl_cnt, 0, 0, 0, fidx);
        dst++;
        left--;
        if (left == 0) level_end(r);
      end
      S_PAD: begin
        pad_cnt--;
        if (pad_cnt == 0) ps = S_SIZE;
      end
      default: ;
    endcase
    if (q.fin) begin
      if (ps != S_DONE && ps != S_ERR) report_error(r, ERR_TRUNCATED);
      parser_clear();
    end
    if (r.size() > 0) r[r.size() - 1].last = 1'b1;
    foreach (r[i]) result_q.insert(result_q.size(), r[i]);
  endtask

  // file builder
  logic [7:0] fbuf[$];

  task automatic put_word(logic [31:0] v, bit swp);
    logic [31:0] x;
    x = swp ? bswap(v) : v;
    for (int i = 0; i < 4; i++) fbuf.insert(fbuf.size(), x[8*i +: 8]);
  endtask

  // flaw: 0 none, 1 ident, 2 endian, 3 format, 4 array, 5 depth, 6 faces
  task automatic build_file(bit swp, int flaw, int fmt, logic [31:0] bw, logic [31:0] bh,
                            int nlev, int kvlen, int maxsz);
    logic [7:0] idb[12];
    logic [31:0] sz;
    idb = '{8'hAB, 8'h4B, 8'h54, 8'h58, 8'h20, 8'h31, 8'h31, 8'hBB,
            8'h0D, 8'h0A, 8'h1A, 8'h0A};
    fbuf.delete();
    foreach (idb[i]) fbuf.insert(fbuf.size(), idb[i]);
    if (flaw == 1) fbuf[$urandom_range(11)] ^= 8'(1 << $urandom_range(7));
    if (flaw == 2) put_word($urandom, 0);
    else put_word(swp ? EndianSwapped : EndianNative, 0);
    put_word($urandom, swp); put_word($urandom, swp); put_word($urandom, swp);
    put_word(flaw == 3 ? ($urandom_range(1) ? $urandom : 32'h9280) : fmt_value(fmt), swp);
    put_word($urandom, swp);
    put_word(bw, swp); put_word(bh, swp);
    put_word(flaw == 5 ? $urandom_range(2, 5) : $urandom_range(1), swp);
    put_word(flaw == 4 ? $urandom_range(1, 3) : 0, swp);
    put_word(flaw == 6 ? 6 : $urandom_range(1), swp);
    put_word(nlev, swp);
    put_word(kvlen, swp);
    for (int i = 0; i < kvlen; i++) fbuf.insert(fbuf.size(), 8'($urandom));
    for (int l = 0; l < (nlev ? nlev : 1); l++) begin
      sz = $urandom_range(maxsz);
      put_word(sz, swp);
      for (int i = 0; i < sz; i++) fbuf.insert(fbuf.size(), 8'($urandom));
      if (l < nlev - 1)
        for (int i = 0; i < ((4 - sz % 4) % 4); i++) fbuf.insert(fbuf.size(), 8'($urandom));
    end
  endtask

  task automatic queue_file(int cut);
    int n;
    req_t q;
    n = (cut > 0 && cut < fbuf.size()) ? cut : fbuf.size();
    for (int i = 0; i < n; i++) begin
      q.b = fbuf[i];
      q.fin = (i == n - 1);
      byte_q.insert(byte_q.size(), q);
    end
  endtask

  task automatic queue_byte(logic [7:0] b, logic fin);
    req_t q;
    q.b = b;
    q.fin = fin;
    byte_q.insert(byte_q.size(), q);
  endtask

  task automatic wait_drain();
    while (byte_q.size() > 0 || result_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // driver: a new request only once the previous one has been accepted
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_byte <= byte_q[0].b;
          last_in <= byte_q[0].fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // accept, predict and check
  always @(posedge clk) begin
    res_t e;
    req_t q;
    if (rst_n) begin
      cycle_cnt <= cycle_cnt + 1;
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        q = byte_q.pop_front();
        predict_byte(q);
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("unexpected result kind=%0d", out_kind);
          errors++;
        end else begin
          e = result_q.pop_front();
          if (out_kind != e.kind) begin
            $error("kind exp %0d got %0d", e.kind, out_kind); errors++;
          end
          if (out_error_code != e.code) begin
            $error("error_code exp %0d got %0d", e.code, out_error_code); errors++;
          end
          if (out_data_byte != e.dbyte) begin
            $error("data_byte exp %0h got %0h", e.dbyte, out_data_byte); errors++;
          end
          if (out_dest_offset != e.off) begin
            $error("dest_offset exp %0h got %0h", e.off, out_dest_offset); errors++;
          end
          if (out_level != e.lvl) begin
            $error("level exp %0d got %0d", e.lvl, out_level); errors++;
          end
          if (out_width != e.w) begin
            $error("width exp %0d got %0d", e.w, out_width); errors++;
          end
          if (out_height != e.h) begin
            $error("height exp %0d got %0d", e.h, out_height); errors++;
          end
          if (out_mip_bytes != e.mb) begin
            $error("mip_bytes exp %0d got %0d", e.mb, out_mip_bytes); errors++;
          end
          if (out_format_code != e.fc) begin
            $error("format_code exp %0d got %0d", e.fc, out_format_code); errors++;
          end
          if (out_last != e.last) begin
            $error("last exp %0d got %0d", e.last, out_last); errors++;
          end
        end
      end
      if (cycle_cnt > CycleLimit) begin
        $display("[ktx_texture_header_parser] ERROR");
        $finish;
      end
    end
  end

  task automatic random_file();
    int sel, flaw, cut;
    sel = $urandom_range(99);
    flaw = (sel < 75) ? 0 : $urandom_range(1, 6);
    build_file($urandom_range(1), flaw, $urandom_range(56), $urandom, $urandom,
               $urandom_range(3), $urandom_range(3) == 0 ? $urandom_range(1, 6) : 0, 9);
    cut = 0;
    if ($urandom_range(9) == 0) cut = $urandom_range(1, fbuf.size());
    queue_file(cut);
    // junk trailing bytes after accept/error, up to last_in
    if (cut == 0 && $urandom_range(4) == 0) begin
      byte_q[byte_q.size() - 1].fin = 1'b0;
      for (int i = 0; i < 3; i++) queue_byte(8'($urandom), 1'b0);
      queue_byte(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    int total;
    parser_clear();
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: both endians, extreme sizes/levels, each rejection, truncations
    build_file(0, 0, 0, 32'hFFFF_FFFF, 32'h1, 0, 0, 0); queue_file(0);
    build_file(1, 0, 56, 32'h8000_0000, 32'hFFFF_FFFF, 34, 5, 3); queue_file(0);
    for (int f = 1; f <= 6; f++) begin
      build_file(f % 2, f, 7, 16, 16, 1, 0, 4); queue_file(0);
    end
    build_file(0, 0, 3, 8, 8, 2, 0, 5); queue_file(30);
    build_file(0, 0, 3, 8, 8, 2, 4, 5); queue_file(64);
    build_file(0, 0, 3, 8, 8, 2, 4, 5); queue_file(66);
    build_file(0, 0, 3, 8, 8, 2, 0, 6); queue_file(70);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b1);
    // huge size word, truncated during payload
    build_file(0, 0, 20, 4, 4, 1, 0, 0); fbuf[64] = 8'hFF; fbuf[65] = 8'hFF;
    fbuf[66] = 8'hFF; fbuf[67] = 8'hFF;
    for (int i = 0; i < 6; i++) fbuf.insert(fbuf.size(), 8'hA5);
    queue_file(0);
    wait_drain();

    total = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 82 : 0;
      recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 30 : 0;
      if (ph == 2) hold_cycles = 300;
      while (total < 240 * (ph + 1)) begin
        random_file();
        total = total + fbuf.size();
      end
      wait_drain();
    end

    if (errors == 0) $display("[ktx_texture_header_parser] OK");
    else $display("[ktx_texture_header_parser] ERROR");
    $finish;
  end

endmodule
